// File: hw/rtl/rgb_rle_pkg.sv
`timescale 1ns / 1ps

package rgb_rle_pkg;

	localparam int LITERAL_MAX_DEF = 128;
	localparam int RUN_MAX         = 129;
	localparam int PIX_W           = 16;
	localparam int BYTE_W          = 8;
	localparam int WORD_BYTES      = 8;
	localparam int WORD_W          = WORD_BYTES * BYTE_W;
	localparam int PACK_W          = WORD_W - BYTE_W;
	localparam int FILL_W          = 3;
	localparam int CNT_W           = 4;
	localparam int RUN_W           = 8;
	localparam logic [BYTE_W-1:0] RUN_TAG_BASE = 8'h80;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP,
		ST_EQ_INC,
		ST_SWAP,
		ST_END,
		ST_DONE,
		ST_RUN_TAG,
		ST_RUN_LO,
		ST_RUN_HI,
		ST_LIT_TAG,
		ST_LIT_LO,
		ST_LIT_HI
	} state_t;

	typedef enum logic [2:0] {
		SEL_TAG_RUN,
		SEL_TAG_LIT,
		SEL_HELD_LO,
		SEL_HELD_HI,
		SEL_RAM_LO,
		SEL_RAM_HI
	} byte_sel_t;

	typedef struct packed {
		logic      in_load;
		logic      hold_load;
		logic      hold_from_port;
		logic      run_inc;
		logic      run_clear;
		logic      lit_write;
		logic      lit_clear;
		logic      rd_en;
		logic      rd_first;
		logic      byte_valid;
		logic      byte_final;
		byte_sel_t byte_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic held_valid;
		logic eq_in;
		logic eq_q;
		logic run_ge2;
		logic run_next_cap;
		logic run_cap;
		logic lit_nz;
		logic lit_next_full;
		logic k_last;
		logic last_q;
		logic byte_ok;
	} dp_stat_t;

endpackage

// File: hw/rtl/rgb_rle_ram.sv
`timescale 1ns / 1ps

module rgb_rle_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/rgb_rle_ctrl.sv
`timescale 1ns / 1ps

module rgb_rle_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  row_end,
	output logic                  in_ready,
	input  rgb_rle_pkg::dp_stat_t stat,
	output rgb_rle_pkg::dp_cmd_t  cmd
);

	rgb_rle_pkg::state_t state_q, state_d;
	rgb_rle_pkg::state_t ret_q, ret_d;

	logic quick_hold;
	logic quick_inc;
	logic quick_lit;
	logic quick;
	logic final_ret;

	// items that code no bytes finish in the accept cycle
	always_comb begin
		quick_hold = !row_end && !stat.held_valid;
		quick_inc  = !row_end && stat.held_valid && stat.eq_in &&
			!(!stat.run_ge2 && stat.lit_nz) && !stat.run_next_cap;
		quick_lit  = !row_end && stat.held_valid && !stat.eq_in &&
			!stat.run_ge2 && !stat.lit_next_full;
		quick      = quick_hold || quick_inc || quick_lit;
		final_ret  = stat.last_q && (ret_q == rgb_rle_pkg::ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgb_rle_pkg::ST_IDLE;
			ret_q   <= rgb_rle_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			rgb_rle_pkg::ST_IDLE: begin
				if (in_valid && !quick) begin
					state_d = rgb_rle_pkg::ST_STEP;
				end
			end
			rgb_rle_pkg::ST_STEP: begin
				if (!stat.held_valid) begin
					state_d = stat.last_q ? rgb_rle_pkg::ST_END : rgb_rle_pkg::ST_IDLE;
				end else if (stat.eq_q) begin
					if (!stat.run_ge2 && stat.lit_nz) begin
						ret_d   = rgb_rle_pkg::ST_EQ_INC;
						state_d = rgb_rle_pkg::ST_LIT_TAG;
					end else begin
						state_d = rgb_rle_pkg::ST_EQ_INC;
					end
				end else if (stat.run_ge2) begin
					ret_d   = rgb_rle_pkg::ST_SWAP;
					state_d = rgb_rle_pkg::ST_RUN_TAG;
				end else if (stat.lit_next_full) begin
					ret_d   = rgb_rle_pkg::ST_SWAP;
					state_d = rgb_rle_pkg::ST_LIT_TAG;
				end else begin
					state_d = rgb_rle_pkg::ST_SWAP;
				end
			end
			rgb_rle_pkg::ST_EQ_INC: begin
				if (stat.run_next_cap) begin
					ret_d   = stat.last_q ? rgb_rle_pkg::ST_DONE : rgb_rle_pkg::ST_IDLE;
					state_d = rgb_rle_pkg::ST_RUN_TAG;
				end else begin
					state_d = stat.last_q ? rgb_rle_pkg::ST_END : rgb_rle_pkg::ST_IDLE;
				end
			end
			rgb_rle_pkg::ST_SWAP: begin
				state_d = stat.last_q ? rgb_rle_pkg::ST_END : rgb_rle_pkg::ST_IDLE;
			end
			rgb_rle_pkg::ST_END: begin
				ret_d   = rgb_rle_pkg::ST_DONE;
				state_d = stat.run_ge2 ? rgb_rle_pkg::ST_RUN_TAG : rgb_rle_pkg::ST_LIT_TAG;
			end
			rgb_rle_pkg::ST_DONE: begin
				state_d = rgb_rle_pkg::ST_IDLE;
			end
			rgb_rle_pkg::ST_RUN_TAG: begin
				if (stat.byte_ok) begin
					state_d = rgb_rle_pkg::ST_RUN_LO;
				end
			end
			rgb_rle_pkg::ST_RUN_LO: begin
				if (stat.byte_ok) begin
					state_d = rgb_rle_pkg::ST_RUN_HI;
				end
			end
			rgb_rle_pkg::ST_RUN_HI: begin
				if (stat.byte_ok) begin
					state_d = ret_q;
				end
			end
			rgb_rle_pkg::ST_LIT_TAG: begin
				if (stat.byte_ok) begin
					state_d = rgb_rle_pkg::ST_LIT_LO;
				end
			end
			rgb_rle_pkg::ST_LIT_LO: begin
				if (stat.byte_ok) begin
					state_d = rgb_rle_pkg::ST_LIT_HI;
				end
			end
			rgb_rle_pkg::ST_LIT_HI: begin
				if (stat.byte_ok) begin
					state_d = stat.k_last ? ret_q : rgb_rle_pkg::ST_LIT_LO;
				end
			end
			default: begin
				state_d = rgb_rle_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.byte_sel = rgb_rle_pkg::SEL_TAG_RUN;
		in_ready     = 1'b0;
		case (state_q)
			rgb_rle_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.in_load = 1'b1;
					if (quick_hold || quick_lit) begin
						cmd.hold_load      = 1'b1;
						cmd.hold_from_port = 1'b1;
					end
					cmd.lit_write = quick_lit;
					cmd.run_inc   = quick_inc;
				end
			end
			rgb_rle_pkg::ST_STEP: begin
				if (!stat.held_valid) begin
					cmd.hold_load = 1'b1;
				end else if (!stat.eq_q && !stat.run_ge2) begin
					cmd.lit_write = 1'b1;
				end
			end
			rgb_rle_pkg::ST_EQ_INC: begin
				cmd.run_inc = 1'b1;
			end
			rgb_rle_pkg::ST_SWAP: begin
				cmd.hold_load = 1'b1;
			end
			rgb_rle_pkg::ST_END: begin
				cmd.lit_write = !stat.run_ge2;
			end
			rgb_rle_pkg::ST_DONE: begin
				cmd.run_clear = 1'b1;
			end
			rgb_rle_pkg::ST_RUN_TAG: begin
				cmd.byte_valid = 1'b1;
				cmd.byte_sel   = rgb_rle_pkg::SEL_TAG_RUN;
			end
			rgb_rle_pkg::ST_RUN_LO: begin
				cmd.byte_valid = 1'b1;
				cmd.byte_sel   = rgb_rle_pkg::SEL_HELD_LO;
			end
			rgb_rle_pkg::ST_RUN_HI: begin
				cmd.byte_valid = 1'b1;
				cmd.byte_sel   = rgb_rle_pkg::SEL_HELD_HI;
				cmd.byte_final = final_ret;
				// a capped run restarts coding at the next pixel
				cmd.run_clear  = stat.byte_ok && stat.run_cap;
			end
			rgb_rle_pkg::ST_LIT_TAG: begin
				cmd.byte_valid = 1'b1;
				cmd.byte_sel   = rgb_rle_pkg::SEL_TAG_LIT;
				cmd.rd_en      = 1'b1;
				cmd.rd_first   = 1'b1;
			end
			rgb_rle_pkg::ST_LIT_LO: begin
				cmd.byte_valid = 1'b1;
				cmd.byte_sel   = rgb_rle_pkg::SEL_RAM_LO;
			end
			rgb_rle_pkg::ST_LIT_HI: begin
				cmd.byte_valid = 1'b1;
				cmd.byte_sel   = rgb_rle_pkg::SEL_RAM_HI;
				cmd.byte_final = stat.k_last && final_ret;
				cmd.lit_clear  = stat.byte_ok && stat.k_last;
				// next read only once this byte is taken, so a stall keeps rdata
				cmd.rd_en      = stat.byte_ok && !stat.k_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: hw/rtl/rgb_rle_dp.sv
`timescale 1ns / 1ps

module rgb_rle_dp #(
	parameter int LITERAL_MAX = rgb_rle_pkg::LITERAL_MAX_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [rgb_rle_pkg::PIX_W-1:0]        pixel,
	input  logic                                 row_end,
	input  rgb_rle_pkg::dp_cmd_t                 cmd,
	output rgb_rle_pkg::dp_stat_t                stat,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rgb_rle_pkg::WORD_W-1:0]       packed_bytes,
	output logic [rgb_rle_pkg::CNT_W-1:0]        byte_count,
	output logic                                 stream_end
);

	localparam int LIT_CW = $clog2(LITERAL_MAX + 1);
	localparam int LIT_AW = $clog2(LITERAL_MAX);
	localparam int PW     = rgb_rle_pkg::PIX_W;
	localparam int BW     = rgb_rle_pkg::BYTE_W;
	localparam int WW     = rgb_rle_pkg::WORD_W;
	localparam int KW     = rgb_rle_pkg::PACK_W;
	localparam int FW     = rgb_rle_pkg::FILL_W;
	localparam int CW     = rgb_rle_pkg::CNT_W;
	localparam int RW     = rgb_rle_pkg::RUN_W;
	localparam int NB     = rgb_rle_pkg::WORD_BYTES;
	localparam logic [RW-1:0]     RUN_CAP  = RW'(rgb_rle_pkg::RUN_MAX);
	localparam logic [LIT_CW-1:0] LIT_FULL = LIT_CW'(LITERAL_MAX);

	logic [PW-1:0]     pix_q;
	logic              last_q;
	logic [PW-1:0]     held_q;
	logic              hv_q;
	logic [RW-1:0]     run_q;
	logic [LIT_CW-1:0] lit_q;
	logic [LIT_AW-1:0] k_q;
	logic [KW-1:0]     pack_q;
	logic [FW-1:0]     fill_q;
	logic              out_valid_q;
	logic [WW-1:0]     out_word_q;
	logic [CW-1:0]     out_cnt_q;
	logic              out_end_q;

	logic [PW-1:0]     rd_pix;
	logic [LIT_AW-1:0] k_next;
	logic [LIT_AW-1:0] raddr;
	logic [BW-1:0]     byte_d;
	logic [WW-1:0]     ins_word;
	logic [WW-1:0]     word_d;
	logic              need_emit;
	logic              byte_ok;
	logic              byte_fire;

	rgb_rle_ram #(
		.WIDTH(PW),
		.DEPTH(LITERAL_MAX)
	) u_lit_store (
		.clk  (clk),
		.we   (cmd.lit_write),
		.waddr(lit_q[LIT_AW-1:0]),
		.wdata(held_q),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rd_pix)
	);

	assign k_next = k_q + 1'b1;
	assign raddr  = cmd.rd_first ? '0 : k_next;

	always_comb begin
		case (cmd.byte_sel)
			rgb_rle_pkg::SEL_TAG_RUN: byte_d = rgb_rle_pkg::RUN_TAG_BASE + run_q - 8'd2;
			rgb_rle_pkg::SEL_TAG_LIT: byte_d = BW'(lit_q - 1'b1);
			rgb_rle_pkg::SEL_HELD_LO: byte_d = held_q[BW-1:0];
			rgb_rle_pkg::SEL_HELD_HI: byte_d = held_q[PW-1:BW];
			rgb_rle_pkg::SEL_RAM_LO:  byte_d = rd_pix[BW-1:0];
			rgb_rle_pkg::SEL_RAM_HI:  byte_d = rd_pix[PW-1:BW];
			default:                  byte_d = '0;
		endcase
	end

	// lanes above the fill point of pack_q are always zero
	always_comb begin
		ins_word = '0;
		for (int i = 0; i < NB; i++) begin
			if (FW'(i) == fill_q) begin
				ins_word[i*BW +: BW] = byte_d;
			end
		end
		word_d = {{BW{1'b0}}, pack_q} | ins_word;
	end

	assign need_emit = (fill_q == FW'(NB - 1)) || cmd.byte_final;
	assign byte_ok   = !need_emit || !out_valid_q || out_ready;
	assign byte_fire = cmd.byte_valid && byte_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= 1'b0;
			hv_q        <= 1'b0;
			run_q       <= '0;
			lit_q       <= '0;
			k_q         <= '0;
			pack_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.in_load) begin
				last_q <= row_end;
			end
			if (cmd.hold_load) begin
				hv_q  <= 1'b1;
				run_q <= RW'(1);
			end else if (cmd.run_clear) begin
				hv_q  <= 1'b0;
				run_q <= '0;
			end else if (cmd.run_inc) begin
				run_q <= run_q + 1'b1;
			end
			if (cmd.lit_clear) begin
				lit_q <= '0;
			end else if (cmd.lit_write) begin
				lit_q <= lit_q + 1'b1;
			end
			if (cmd.rd_en) begin
				k_q <= cmd.rd_first ? '0 : k_next;
			end
			if (byte_fire) begin
				if (need_emit) begin
					pack_q <= '0;
					fill_q <= '0;
				end else begin
					pack_q <= word_d[KW-1:0];
					fill_q <= fill_q + 1'b1;
				end
			end
			if (byte_fire && need_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			pix_q <= pixel;
		end
		if (cmd.hold_load) begin
			held_q <= cmd.hold_from_port ? pixel : pix_q;
		end
		if (byte_fire && need_emit) begin
			out_word_q <= word_d;
			out_cnt_q  <= CW'(fill_q) + 1'b1;
			out_end_q  <= cmd.byte_final;
		end
	end

	always_comb begin
		stat.held_valid    = hv_q;
		stat.eq_in         = (pixel == held_q);
		stat.eq_q          = (pix_q == held_q);
		stat.run_ge2       = (run_q >= RW'(2));
		stat.run_next_cap  = (run_q + 1'b1 == RUN_CAP);
		stat.run_cap       = (run_q == RUN_CAP);
		stat.lit_nz        = (lit_q != '0);
		stat.lit_next_full = (lit_q + 1'b1 == LIT_FULL);
		stat.k_last        = (LIT_CW'(k_q) + 1'b1 == lit_q);
		stat.last_q        = last_q;
		stat.byte_ok       = byte_ok;
	end

	assign out_valid    = out_valid_q;
	assign packed_bytes = out_word_q;
	assign byte_count   = out_cnt_q;
	assign stream_end   = out_end_q;

endmodule

// File: hw/rtl/rgb565_row_rle_encoder.sv
`timescale 1ns / 1ps

// channel | handshake           | payload
// --------+---------------------+----------------------------------------
// input   | in_valid, in_ready  | pixel[15:0], row_end
// output  | out_valid, out_ready| packed_bytes[63:0], byte_count[3:0], stream_end
//
// A pixel that codes no byte is taken in its accept cycle, back to back.
// Otherwise one coded byte per cycle while no word stalls, around control states
// ST_STEP, ST_EQ_INC or ST_SWAP (ST_END, ST_DONE at row end); a literal of n
// pixels drains a tag and 2n bytes through the literal store's single read port.
// Reset is asynchronous; the literal store needs no clearing pass.
// Words wait in an output register; the byte sequencer stalls only when a word
// completes while that register is still held.

module rgb565_row_rle_encoder #(
	parameter int LITERAL_MAX = rgb_rle_pkg::LITERAL_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rgb_rle_pkg::PIX_W-1:0]    pixel,
	input  logic                             row_end,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [rgb_rle_pkg::WORD_W-1:0]   packed_bytes,
	output logic [rgb_rle_pkg::CNT_W-1:0]    byte_count,
	output logic                             stream_end
);

	rgb_rle_pkg::dp_cmd_t  cmd;
	rgb_rle_pkg::dp_stat_t stat;

	rgb_rle_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.row_end (row_end),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	rgb_rle_dp #(
		.LITERAL_MAX(LITERAL_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel       (pixel),
		.row_end     (row_end),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packed_bytes(packed_bytes),
		.byte_count  (byte_count),
		.stream_end  (stream_end)
	);

endmodule
